// ===== rtl/smcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial motion command parser package
// Shared constants, types and character helpers for the command parser.
// ----------------------------------------------------------------------------
package smcp_pkg;

	localparam int MAX_COMMAND_BYTES = 64;
	localparam int CNT_W = $clog2(MAX_COMMAND_BYTES + 1);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COMMAND_BYTES);
	localparam logic [CNT_W-1:0] CNT_FRAME_LIMIT = CNT_W'(MAX_COMMAND_BYTES - 2);

	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [8:0] MAX_ANGLE_RST    = 9'd360;
	localparam logic [5:0] MAX_SPEED_RST    = 6'd30;
	localparam logic [5:0] ROTATE_SPEED_RST = 6'd20;
	localparam logic [9:0] ACCUM_MAX        = 10'd1023;

	typedef enum logic [1:0] {
		CFG_MAX_ANGLE    = 2'd0,
		CFG_MAX_SPEED    = 2'd1,
		CFG_ROTATE_SPEED = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		KIND_MOVE       = 3'd0,
		KIND_ROTATE_CW  = 3'd1,
		KIND_ROTATE_ACW = 3'd2,
		KIND_STOP       = 3'd3,
		KIND_UNKNOWN    = 3'd4
	} cmd_kind_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} num_phase_t;

	typedef struct packed {
		logic [9:0] acc;
		num_phase_t phase;
		logic       neg;
	} num_state_t;

	typedef struct packed {
		logic [8:0] max_angle;
		logic [5:0] max_speed;
		logic [5:0] rotate_speed;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [8:0] angle;
		logic [5:0] speed;
		logic [7:0] unknown_char;
	} cmd_result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ===== rtl/smcp_if.sv =====
// ----------------------------------------------------------------------------
// Serial motion command parser channels
// Valid/ready channels for received bytes and for decoded commands.
// ----------------------------------------------------------------------------
interface smcp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface smcp_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] command_kind;
	logic [8:0] move_angle;
	logic [5:0] drive_speed;
	logic [7:0] unknown_char;

	modport source (output valid, output command_kind, output move_angle,
		output drive_speed, output unknown_char, input ready);
	modport sink (input valid, input command_kind, input move_angle,
		input drive_speed, input unknown_char, output ready);
endinterface

// ===== rtl/serial_motion_command_parser.sv =====
// ----------------------------------------------------------------------------
// Serial motion command parser
// Frames received bytes into '?'-terminated commands and decodes them.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel, one item per byte. Each byte updates
// the frame state as it is accepted, so no frame buffer is kept. A '?' that
// closes a well-formed frame produces one command item on the cmd channel;
// all other bytes produce nothing.
// A byte is taken every cycle while rx ready is high. A command appears on cmd
// in the cycle after the '?' that ends it is accepted and sits in an output
// register until taken. The rx channel keeps accepting while that register is
// empty or is being emptied in the same cycle; when the receiver stalls with a
// command held, rx ready drops until it is taken.
// The configuration port writes max_angle, max_speed and rotate_speed by
// index; writes are meant for when no command is pending.
// Reset clears the frame state and the output register's valid flag and loads
// the default limits 360, 30 and 20.
// ----------------------------------------------------------------------------
module serial_motion_command_parser (
	input  logic             clk,
	input  logic             arst_n,
	smcp_rx_if.sink          rx,
	smcp_cmd_if.source       cmd,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [8:0]       cfg_data
);

	smcp_pkg::cfg_t        cfg_q;
	smcp_pkg::cmd_result_t res;
	smcp_pkg::cmd_result_t out_q;
	logic                  res_valid;
	logic                  out_valid_q;
	logic                  accept;

	assign rx.ready = !out_valid_q || cmd.ready;
	assign accept = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_angle <= smcp_pkg::MAX_ANGLE_RST;
			cfg_q.max_speed <= smcp_pkg::MAX_SPEED_RST;
			cfg_q.rotate_speed <= smcp_pkg::ROTATE_SPEED_RST;
		end else if (cfg_we) begin
			case (smcp_pkg::cfg_index_t'(cfg_index))
				smcp_pkg::CFG_MAX_ANGLE: cfg_q.max_angle <= cfg_data;
				smcp_pkg::CFG_MAX_SPEED: cfg_q.max_speed <= cfg_data[5:0];
				smcp_pkg::CFG_ROTATE_SPEED: cfg_q.rotate_speed <= cfg_data[5:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	smcp_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx.rx_byte),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign cmd.valid = out_valid_q;
	assign cmd.command_kind = out_q.kind;
	assign cmd.move_angle = out_q.angle;
	assign cmd.drive_speed = out_q.speed;
	assign cmd.unknown_char = out_q.unknown_char;

	a_unknown_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind != smcp_pkg::KIND_UNKNOWN |-> out_q.unknown_char == 8'd0)
		else $error("unknown byte reported on a known command");

	a_angle_only_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind != smcp_pkg::KIND_MOVE |-> out_q.angle == 9'd0)
		else $error("angle reported on a command that is not a move");

	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == smcp_pkg::KIND_STOP |-> out_q.speed == 6'd0)
		else $error("speed reported on a stop command");

endmodule

// ===== rtl/smcp_number.sv =====
// ----------------------------------------------------------------------------
// Decimal field reader
// Next-state logic for one signed decimal field read one byte at a time.
// ----------------------------------------------------------------------------
module smcp_number (
	input  logic [7:0]          c,
	input  smcp_pkg::num_state_t cur,
	output smcp_pkg::num_state_t nxt
);

	logic        run;
	logic [13:0] sum;
	logic [9:0]  sat;

	assign sum = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {10'b0, c[3:0]};
	assign sat = (sum > {4'b0, smcp_pkg::ACCUM_MAX}) ? smcp_pkg::ACCUM_MAX : sum[9:0];

	always_comb begin
		nxt = cur;
		run = 1'b0;
		case (cur.phase)
			smcp_pkg::PH_SKIP: begin
				if (smcp_pkg::is_space(c)) begin
					run = 1'b0;
				end else if (c == smcp_pkg::CH_PLUS || c == smcp_pkg::CH_MINUS) begin
					nxt.neg = (c == smcp_pkg::CH_MINUS);
					nxt.phase = smcp_pkg::PH_DIGITS;
				end else begin
					nxt.phase = smcp_pkg::PH_DIGITS;
					run = 1'b1;
				end
			end
			smcp_pkg::PH_DIGITS: begin
				run = 1'b1;
			end
			default: begin
				run = 1'b0;
			end
		endcase
		if (run) begin
			if (smcp_pkg::is_digit(c)) begin
				nxt.acc = sat;
			end else begin
				nxt.phase = smcp_pkg::PH_DONE;
			end
		end
	end

endmodule

// ===== rtl/smcp_frame.sv =====
// ----------------------------------------------------------------------------
// Command framer and decoder
// Tracks the current frame byte by byte and decodes it when '?' arrives.
// ----------------------------------------------------------------------------
module smcp_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	input  smcp_pkg::cfg_t        cfg,
	output logic                  res_valid,
	output smcp_pkg::cmd_result_t res
);

	logic [smcp_pkg::CNT_W-1:0] byte_cnt_q;
	logic [7:0]                 lead_q;
	logic [7:0]                 third_q;
	logic [1:0]                 comma_q;
	smcp_pkg::num_state_t       angle_q;
	smcp_pkg::num_state_t       speed_q;
	smcp_pkg::num_state_t       angle_nx;
	smcp_pkg::num_state_t       speed_nx;
	logic                       is_end;
	logic                       frame_ok;
	logic                       angle_bad;
	logic                       speed_bad;

	smcp_number u_angle (.c(rx_byte), .cur(angle_q), .nxt(angle_nx));
	smcp_number u_speed (.c(rx_byte), .cur(speed_q), .nxt(speed_nx));

	assign is_end = (rx_byte == smcp_pkg::CH_QMARK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			lead_q <= '0;
			third_q <= '0;
			comma_q <= '0;
			angle_q <= '0;
			speed_q <= '0;
		end else if (accept) begin
			if (is_end || byte_cnt_q >= smcp_pkg::CNT_MAX) begin
				byte_cnt_q <= '0;
				lead_q <= '0;
				third_q <= '0;
				comma_q <= '0;
				angle_q <= '0;
				speed_q <= '0;
			end else begin
				if (byte_cnt_q == smcp_pkg::CNT_W'(0)) begin
					lead_q <= rx_byte;
				end
				if (byte_cnt_q == smcp_pkg::CNT_W'(2)) begin
					third_q <= rx_byte;
				end
				if (byte_cnt_q != smcp_pkg::CNT_W'(0)) begin
					if (rx_byte == smcp_pkg::CH_COMMA && comma_q < 2'd2) begin
						comma_q <= comma_q + 2'd1;
					end else if (comma_q == 2'd1) begin
						angle_q <= angle_nx;
					end else if (comma_q == 2'd2) begin
						speed_q <= speed_nx;
					end
				end
				byte_cnt_q <= byte_cnt_q + smcp_pkg::CNT_W'(1);
			end
		end
	end

	assign frame_ok = (byte_cnt_q != smcp_pkg::CNT_W'(0))
		&& (byte_cnt_q <= smcp_pkg::CNT_FRAME_LIMIT);
	assign angle_bad = (angle_q.neg && angle_q.acc != 10'd0)
		|| (angle_q.acc > {1'b0, cfg.max_angle});
	assign speed_bad = (speed_q.neg && speed_q.acc != 10'd0)
		|| (speed_q.acc > {4'b0, cfg.max_speed});

	always_comb begin
		res = '0;
		res.kind = smcp_pkg::KIND_MOVE;
		res_valid = 1'b0;
		if (accept && is_end && frame_ok) begin
			case (lead_q)
				smcp_pkg::CH_ONE: begin
					res_valid = (comma_q == 2'd2);
					res.angle = angle_bad ? 9'd0 : angle_q.acc[8:0];
					res.speed = speed_bad ? 6'd0 : speed_q.acc[5:0];
				end
				smcp_pkg::CH_TWO: begin
					res_valid = (byte_cnt_q >= smcp_pkg::CNT_W'(3))
						&& (third_q == smcp_pkg::CH_ONE || third_q == smcp_pkg::CH_TWO);
					res.kind = (third_q == smcp_pkg::CH_ONE) ? smcp_pkg::KIND_ROTATE_CW
						: smcp_pkg::KIND_ROTATE_ACW;
					res.speed = cfg.rotate_speed;
				end
				smcp_pkg::CH_THREE: begin
					res_valid = 1'b1;
					res.kind = smcp_pkg::KIND_STOP;
				end
				default: begin
					res_valid = 1'b1;
					res.kind = smcp_pkg::KIND_UNKNOWN;
					res.unknown_char = lead_q;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= smcp_pkg::CNT_MAX)
		else $error("frame byte count beyond its limit");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_end |=> byte_cnt_q == smcp_pkg::CNT_W'(0) && comma_q == 2'd0)
		else $error("frame state not cleared after end of frame");

	a_comma_bound: assert property (@(posedge clk) disable iff (!arst_n)
		comma_q <= 2'd2)
		else $error("comma count beyond two");

endmodule

// ===== tb/tb_serial_motion_command_parser.sv =====
// ----------------------------------------------------------------------------
// Serial motion command parser testbench
// Feeds received bytes through the rx channel and checks every command that
// appears on the cmd channel against a byte-by-byte prediction kept in a
// scoreboard. Directed frames cover the field extremes, each command form and
// the framing corner cases; random frames follow under several limit settings
// with random idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_serial_motion_command_parser;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;

	class command_scoreboard;
		smcp_pkg::cfg_t        limits;
		int unsigned           frame_len;
		logic [7:0]            lead_byte;
		logic [7:0]            third_byte;
		int unsigned           commas;
		smcp_pkg::num_state_t  angle_num;
		smcp_pkg::num_state_t  speed_num;
		smcp_pkg::cmd_result_t pending_cmds[$];
		int unsigned           errors;
		int unsigned           bytes_seen;
		int unsigned           cmds_checked;
		int unsigned           kind_seen[5];

		function new();
			limits.max_angle = smcp_pkg::MAX_ANGLE_RST;
			limits.max_speed = smcp_pkg::MAX_SPEED_RST;
			limits.rotate_speed = smcp_pkg::ROTATE_SPEED_RST;
			clear_frame();
		endfunction

		function void clear_frame();
			frame_len = 0;
			lead_byte = '0;
			third_byte = '0;
			commas = 0;
			angle_num = '0;
			speed_num = '0;
		endfunction

		function void set_limit(smcp_pkg::cfg_index_t idx, logic [8:0] value);
			case (idx)
				smcp_pkg::CFG_MAX_ANGLE: limits.max_angle = value;
				smcp_pkg::CFG_MAX_SPEED: limits.max_speed = value[5:0];
				smcp_pkg::CFG_ROTATE_SPEED: limits.rotate_speed = value[5:0];
				default: ;
			endcase
		endfunction

		function smcp_pkg::num_state_t parse_digit(smcp_pkg::num_state_t n, logic [7:0] c);
			int v;
			if (n.phase == smcp_pkg::PH_SKIP) begin
				if (c == smcp_pkg::CH_SPACE || (c >= smcp_pkg::CH_TAB && c <= smcp_pkg::CH_CR))
					return n;
				if (c == smcp_pkg::CH_PLUS || c == smcp_pkg::CH_MINUS) begin
					n.neg = (c == smcp_pkg::CH_MINUS);
					n.phase = smcp_pkg::PH_DIGITS;
					return n;
				end
				n.phase = smcp_pkg::PH_DIGITS;
			end
			if (n.phase == smcp_pkg::PH_DIGITS) begin
				if (c >= smcp_pkg::CH_ZERO && c <= smcp_pkg::CH_NINE) begin
					v = int'(n.acc) * 10 + int'(c) - int'(smcp_pkg::CH_ZERO);
					n.acc = (v > int'(smcp_pkg::ACCUM_MAX)) ? smcp_pkg::ACCUM_MAX : v[9:0];
				end else begin
					n.phase = smcp_pkg::PH_DONE;
				end
			end
			return n;
		endfunction

		function logic [9:0] bounded_value(smcp_pkg::num_state_t n, logic [9:0] limit);
			if (n.neg && n.acc != 0)
				return '0;
			return (n.acc > limit) ? '0 : n.acc;
		endfunction

		function void note_byte(logic [7:0] c);
			smcp_pkg::cmd_result_t r;
			bit produced;
			logic [9:0] v;
			bytes_seen++;
			if (c != smcp_pkg::CH_QMARK) begin
				if (frame_len >= smcp_pkg::MAX_COMMAND_BYTES) begin
					clear_frame();
					return;
				end
				if (frame_len == 0)
					lead_byte = c;
				if (frame_len == 2)
					third_byte = c;
				if (frame_len >= 1) begin
					if (c == smcp_pkg::CH_COMMA && commas < 2)
						commas++;
					else if (commas == 1)
						angle_num = parse_digit(angle_num, c);
					else if (commas == 2)
						speed_num = parse_digit(speed_num, c);
				end
				frame_len++;
				return;
			end
			r = '0;
			produced = 0;
			if (frame_len != 0 && frame_len + 1 <= smcp_pkg::MAX_COMMAND_BYTES - 1) begin
				case (lead_byte)
					smcp_pkg::CH_ONE: begin
						if (commas == 2) begin
							r.kind = smcp_pkg::KIND_MOVE;
							v = bounded_value(angle_num, 10'(limits.max_angle));
							r.angle = v[8:0];
							v = bounded_value(speed_num, 10'(limits.max_speed));
							r.speed = v[5:0];
							produced = 1;
						end
					end
					smcp_pkg::CH_TWO: begin
						if (frame_len >= 3 && (third_byte == smcp_pkg::CH_ONE
							|| third_byte == smcp_pkg::CH_TWO)) begin
							r.kind = (third_byte == smcp_pkg::CH_ONE) ? smcp_pkg::KIND_ROTATE_CW
								: smcp_pkg::KIND_ROTATE_ACW;
							r.speed = limits.rotate_speed;
							produced = 1;
						end
					end
					smcp_pkg::CH_THREE: begin
						r.kind = smcp_pkg::KIND_STOP;
						produced = 1;
					end
					default: begin
						r.kind = smcp_pkg::KIND_UNKNOWN;
						r.unknown_char = lead_byte;
						produced = 1;
					end
				endcase
			end
			if (produced)
				pending_cmds.push_back(r);
			clear_frame();
		endfunction

		function void check_command(smcp_pkg::cmd_result_t got);
			smcp_pkg::cmd_result_t want;
			if (pending_cmds.size() == 0) begin
				$error("command item with none expected: kind %0d angle %0d speed %0d char %0d",
					got.kind, got.angle, got.speed, got.unknown_char);
				errors++;
				return;
			end
			want = pending_cmds.pop_front();
			cmds_checked++;
			kind_seen[want.kind]++;
			if (got.kind !== want.kind) begin
				$error("command_kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.angle !== want.angle) begin
				$error("move_angle mismatch: expected %0d, actual %0d", want.angle, got.angle);
				errors++;
			end
			if (got.speed !== want.speed) begin
				$error("drive_speed mismatch: expected %0d, actual %0d", want.speed, got.speed);
				errors++;
			end
			if (got.unknown_char !== want.unknown_char) begin
				$error("unknown_char mismatch: expected %0d, actual %0d",
					want.unknown_char, got.unknown_char);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	smcp_rx_if rx();
	smcp_cmd_if cmd();

	serial_motion_command_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	command_scoreboard sb = new();
	logic [7:0] frame_buf[$];
	smcp_pkg::cmd_result_t seen_cmd;
	bit idle_on;
	int unsigned hold_requested;
	int unsigned hold_served;
	int unsigned hold_left;
	int unsigned cycle_count;
	int unsigned frames_sent;
	int unsigned settings_used;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx.valid && rx.ready)
				sb.note_byte(rx.rx_byte);
			if (cmd.valid && cmd.ready) begin
				seen_cmd.kind = smcp_pkg::cmd_kind_t'(cmd.command_kind);
				seen_cmd.angle = cmd.move_angle;
				seen_cmd.speed = cmd.drive_speed;
				seen_cmd.unknown_char = cmd.unknown_char;
				sb.check_command(seen_cmd);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_requested != hold_served) begin
			hold_served = hold_requested;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			cmd.ready = 1'b0;
		end else begin
			cmd.ready = !(idle_on && $urandom_range(0, 99) < 7);
		end
	end

	function automatic logic [7:0] rand_text_byte(bit allow_comma);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == smcp_pkg::CH_QMARK || (!allow_comma && b == smcp_pkg::CH_COMMA));
		return b;
	endfunction

	task automatic send_byte(logic [7:0] b);
		if (idle_on && $urandom_range(0, 99) < 7) begin
			rx.valid = 1'b0;
			@(negedge clk);
		end
		rx.valid = 1'b1;
		rx.rx_byte = b;
		do
			@(posedge clk);
		while (!rx.ready);
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i]);
		send_byte(smcp_pkg::CH_QMARK);
		frame_buf.delete();
		frames_sent++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			frame_buf.push_back(s[i]);
	endtask

	task automatic add_padded_stop(int unsigned len);
		frame_buf.push_back(smcp_pkg::CH_THREE);
		repeat (len - 1) frame_buf.push_back(smcp_pkg::CH_SPACE);
	endtask

	task automatic add_number(int unsigned limit);
		int unsigned v;
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
			case ($urandom_range(0, 5))
				0: frame_buf.push_back(smcp_pkg::CH_SPACE);
				1: frame_buf.push_back(smcp_pkg::CH_TAB);
				2: frame_buf.push_back(8'h0A);
				3: frame_buf.push_back(8'h0B);
				4: frame_buf.push_back(8'h0C);
				default: frame_buf.push_back(smcp_pkg::CH_CR);
			endcase
		end
		case ($urandom_range(0, 9))
			0: frame_buf.push_back(smcp_pkg::CH_MINUS);
			1: frame_buf.push_back(smcp_pkg::CH_PLUS);
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = limit;
			2: v = limit + 1;
			3: v = $urandom_range(1000, 99999);
			default: v = $urandom_range(0, limit + 10);
		endcase
		if ($urandom_range(0, 14) != 0) begin
			if ($urandom_range(0, 9) == 0)
				frame_buf.push_back(smcp_pkg::CH_ZERO);
			add_text($sformatf("%0d", v));
		end
		if ($urandom_range(0, 5) == 0)
			frame_buf.push_back(rand_text_byte(0));
	endtask

	task automatic build_random_frame();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			frame_buf.push_back(smcp_pkg::CH_ONE);
			if ($urandom_range(0, 9) == 0)
				frame_buf.push_back(rand_text_byte(0));
			frame_buf.push_back(smcp_pkg::CH_COMMA);
			add_number(sb.limits.max_angle);
			frame_buf.push_back(smcp_pkg::CH_COMMA);
			add_number(sb.limits.max_speed);
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 4)) frame_buf.push_back(rand_text_byte(1));
		end else if (pick < 50) begin
			frame_buf.push_back(smcp_pkg::CH_TWO);
			if ($urandom_range(0, 7) != 0) begin
				frame_buf.push_back(($urandom_range(0, 4) == 0) ? rand_text_byte(1)
					: smcp_pkg::CH_COMMA);
				if ($urandom_range(0, 5) == 0)
					frame_buf.push_back(rand_text_byte(1));
				else
					frame_buf.push_back($urandom_range(0, 1) ? smcp_pkg::CH_ONE
						: smcp_pkg::CH_TWO);
			end
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) frame_buf.push_back(rand_text_byte(1));
		end else if (pick < 60) begin
			frame_buf.push_back(smcp_pkg::CH_THREE);
			repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0)
				frame_buf.push_back(rand_text_byte(1));
		end else if (pick < 72) begin
			repeat ($urandom_range(1, 6)) frame_buf.push_back(rand_text_byte(1));
		end else if (pick < 77) begin
			frame_buf.delete();
		end else if (pick < 84) begin
			frame_buf.push_back(smcp_pkg::CH_ONE);
			frame_buf.push_back(smcp_pkg::CH_COMMA);
			add_number(sb.limits.max_angle);
		end else if (pick < 94) begin
			repeat ($urandom_range(1, 12))
				frame_buf.push_back(($urandom_range(0, 7) == 0) ? smcp_pkg::CH_QMARK
					: 8'($urandom_range(0, 255)));
		end else if (pick < 98) begin
			frame_buf.push_back(smcp_pkg::CH_THREE);
			repeat ($urandom_range(57, 67)) frame_buf.push_back(rand_text_byte(1));
		end else begin
			repeat ($urandom_range(64, 70)) frame_buf.push_back(rand_text_byte(1));
		end
	endtask

	task automatic run_random(int unsigned byte_budget);
		int unsigned start;
		start = sb.bytes_seen;
		while (sb.bytes_seen - start < byte_budget) begin
			build_random_frame();
			send_frame();
		end
	endtask

	task automatic wait_drained();
		rx.valid = 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(smcp_pkg::cfg_index_t idx, logic [8:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_limit(idx, value);
	endtask

	task automatic write_limits(logic [8:0] angle, logic [5:0] speed, logic [5:0] rot_speed);
		write_limit(smcp_pkg::CFG_MAX_ANGLE, angle);
		write_limit(smcp_pkg::CFG_MAX_SPEED, 9'(speed));
		write_limit(smcp_pkg::CFG_ROTATE_SPEED, 9'(rot_speed));
		settings_used++;
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		cfg_we = 1'b0;
		cfg_index = smcp_pkg::CFG_MAX_ANGLE;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_requested = 0;
		hold_served = 0;
		hold_left = 0;
		settings_used = 1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_text("1,360,30"); send_frame();
		add_text("1,361,31"); send_frame();
		add_text("1, -0,+5"); send_frame();
		add_text("1,-5,\t 7"); send_frame();
		add_text("1,99999,12,3"); send_frame();
		add_text("1,45"); send_frame();
		add_text("1,,"); send_frame();
		add_text("2,1"); send_frame();
		add_text("2,2"); send_frame();
		add_text("2x2"); send_frame();
		add_text("2,3"); send_frame();
		add_text("2"); send_frame();
		add_text("21"); send_frame();
		add_text("3"); send_frame();
		add_text("3abc"); send_frame();
		send_frame();
		add_text("A,1"); send_frame();
		frame_buf.push_back(8'h00); send_frame();
		frame_buf.push_back(8'hFF); send_frame();
		add_padded_stop(62); send_frame();
		add_padded_stop(63); send_frame();
		add_padded_stop(64); send_frame();
		add_padded_stop(66); send_frame();

		run_random(300);
		wait_drained();

		write_limits(9'd511, 6'd63, 6'd63);
		idle_on = 1'b0;
		add_text("1,511,63"); send_frame();
		add_text("1,512,64"); send_frame();
		run_random(320);
		wait_drained();

		write_limits(9'd0, 6'd0, 6'd0);
		idle_on = 1'b1;
		add_text("1,0,0"); send_frame();
		add_text("1,1,1"); send_frame();
		run_random(320);
		wait_drained();

		write_limits(9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)));
		hold_requested++;
		repeat (40) begin
			if ($urandom_range(0, 1))
				add_text("3");
			else
				add_text("2,1");
			send_frame();
		end
		run_random(200);
		wait_drained();

		write_limits(9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)));
		run_random(320);
		wait_drained();

		write_limits(smcp_pkg::MAX_ANGLE_RST, smcp_pkg::MAX_SPEED_RST,
			smcp_pkg::ROTATE_SPEED_RST);
		run_random(80);
		wait_drained();

		if (sb.pending_cmds.size() != 0) begin
			$error("%0d expected command items never arrived", sb.pending_cmds.size());
			sb.errors++;
		end
		$display("Sent %0d bytes in %0d frames under %0d limit settings; checked %0d commands.",
			sb.bytes_seen, frames_sent, settings_used, sb.cmds_checked);
		$display("Commands by kind: move %0d, rotate %0d, stop %0d, unknown %0d.",
			sb.kind_seen[smcp_pkg::KIND_MOVE],
			sb.kind_seen[smcp_pkg::KIND_ROTATE_CW] + sb.kind_seen[smcp_pkg::KIND_ROTATE_ACW],
			sb.kind_seen[smcp_pkg::KIND_STOP], sb.kind_seen[smcp_pkg::KIND_UNKNOWN]);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
